@@ rtl/core/lir_pkg.sv @@
// Shared types, constants and curve lookup tables for the lamp intent resolver.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

    localparam int unsigned BRIGHT_MIN  = 76;
    localparam int unsigned BRIGHT_SPAN = 178;
    localparam int unsigned LEVEL_DEN   = 253;
    localparam int unsigned LEVEL_RND   = 126;
    localparam int unsigned SQ_DEN      = 2 * LEVEL_DEN * LEVEL_DEN;
    localparam int unsigned MIRED_SPAN  = 217;
    localparam int unsigned MIRED_RND   = 108;
    localparam int unsigned TEMP_SCALE  = 100;

    localparam logic [15:0] MIRED_COLD = 16'd153;
    localparam logic [15:0] MIRED_WARM = 16'd370;
    localparam logic [7:0]  LEVEL_MAX  = 8'd254;
    localparam logic [7:0]  DIFF_MAX   = 8'd217;

    localparam logic [1:0] LAMP_FRONT = 2'b01;
    localparam logic [1:0] LAMP_BACK  = 2'b10;
    localparam logic [1:0] LAMP_BOTH  = 2'b11;

    localparam int unsigned INT_POWER  = 0;
    localparam int unsigned INT_FRONT  = 1;
    localparam int unsigned INT_BACK   = 2;
    localparam int unsigned INT_LEVEL  = 3;
    localparam int unsigned INT_MIREDS = 4;
    localparam int unsigned INT_AUTO   = 5;

    localparam int unsigned CHG_POWER  = 0;
    localparam int unsigned CHG_BRIGHT = 1;
    localparam int unsigned CHG_TEMP   = 2;

    localparam logic CURVE_SQUARE = 1'b1;

    typedef struct packed {
        logic        base_power;
        logic [1:0]  base_lamps;
        logic [7:0]  base_bright;
        logic [7:0]  base_temp;
        logic [5:0]  intent_mask;
        logic        want_power;
        logic        want_front;
        logic        want_back;
        logic [7:0]  level;
        logic [15:0] mireds;
        logic [1:0]  memory_lamps;
    } t_in_word;

    typedef struct packed {
        logic       target_power;
        logic [1:0] target_lamps;
        logic [7:0] target_bright;
        logic [7:0] target_temp;
        logic [2:0] changed_fields;
        logic       fire_auto;
    } t_out_word;

    typedef struct packed {
        logic       power;
        logic [1:0] lamps;
        logic [2:0] changed;
        logic       fire;
    } t_lamp_res;

    typedef logic [255:0][7:0] t_tab;

    function automatic t_tab build_lin_tab();
        t_tab        tab;
        int unsigned v;
        for (int unsigned i = 0; i < 256; i++) begin
            v = (i * BRIGHT_SPAN + LEVEL_RND) / LEVEL_DEN;
            if (v > BRIGHT_SPAN) begin
                v = BRIGHT_SPAN;
            end
            tab[i] = 8'(v);
        end
        return tab;
    endfunction

    function automatic t_tab build_sq_tab();
        t_tab        tab;
        int unsigned v;
        for (int unsigned i = 0; i < 256; i++) begin
            v = (2 * BRIGHT_SPAN * i * i + LEVEL_DEN * LEVEL_DEN) / SQ_DEN;
            if (v > BRIGHT_SPAN) begin
                v = BRIGHT_SPAN;
            end
            tab[i] = 8'(v);
        end
        return tab;
    endfunction

    function automatic t_tab build_temp_tab();
        t_tab        tab;
        int unsigned d;
        for (int unsigned i = 0; i < 256; i++) begin
            d = (i > MIRED_SPAN) ? MIRED_SPAN : i;
            tab[i] = 8'((d * TEMP_SCALE + MIRED_RND) / MIRED_SPAN);
        end
        return tab;
    endfunction

    localparam t_tab LIN_TAB  = build_lin_tab();
    localparam t_tab SQ_TAB   = build_sq_tab();
    localparam t_tab TEMP_TAB = build_temp_tab();

endpackage

`default_nettype wire

@@ rtl/core/lamp_intent_resolver_core.sv @@
// Top level of the lamp intent resolver: input register, resolve logic, result register.
// The block takes one intent word per clock while o_stall is low and returns one result word
// for each. An accepted word moves from the input register to the result register, which
// drives the output. Throughput is one word per cycle while the output is not stalled; the
// input register and the result register hold the two pipeline stages. A stall on the output
// backs up into the input stall only when both registers are full. The curve mode register
// resets to the square curve and is written whenever i_cfg_we is high.
`timescale 1ns / 1ps
`default_nettype none

module lamp_intent_resolver_core
    import lir_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_cfg_we,
    input  var logic      i_cfg_wdata,
    input  var logic      i_valid,
    output var logic      o_stall,
    input  var t_in_word  i_word,
    output var logic      o_valid,
    input  var logic      i_stall,
    output var t_out_word o_word
);

    logic      r_curve_mode;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      n_in_valid;
    logic      n_out_valid;
    logic      adv_out;
    logic      adv_in;
    t_lamp_res res;
    logic [7:0] bright;
    logic [7:0] temp;
    t_out_word n_out_word;

    assign adv_out = ~r_out_valid | ~i_stall;
    assign adv_in  = ~r_in_valid | adv_out;
    assign o_stall = ~adv_in;

    assign n_in_valid  = adv_in ? i_valid : r_in_valid;
    assign n_out_valid = adv_out ? r_in_valid : r_out_valid;

    lir_rules u_rules (
        .i_word (r_in_word),
        .o_res  (res)
    );

    lir_bright u_bright (
        .i_curve_mode  (r_curve_mode),
        .i_use_level   (r_in_word.intent_mask[INT_LEVEL]),
        .i_level       (r_in_word.level),
        .i_base_bright (r_in_word.base_bright),
        .o_bright      (bright)
    );

    lir_temp u_temp (
        .i_use_mireds (r_in_word.intent_mask[INT_MIREDS]),
        .i_mireds     (r_in_word.mireds),
        .i_base_temp  (r_in_word.base_temp),
        .o_temp       (temp)
    );

    always_comb begin
        n_out_word                = '0;
        n_out_word.target_power   = res.power;
        n_out_word.target_lamps   = res.lamps;
        n_out_word.target_bright  = bright;
        n_out_word.target_temp    = temp;
        n_out_word.changed_fields = res.changed;
        n_out_word.fire_auto      = res.fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= CURVE_SQUARE;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_curve_mode <= i_cfg_wdata;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_in_word <= i_word;
        end
        if (adv_out) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

`default_nettype wire

@@ rtl/core/lir_rules.sv @@
// Power and lamp selection rules, change mask and auto-mode trigger.
`timescale 1ns / 1ps
`default_nettype none

module lir_rules
    import lir_pkg::*;
(
    input  var t_in_word  i_word,
    output var t_lamp_res o_res
);

    logic [5:0] has;
    logic [1:0] mem;
    logic       sel;
    logic       flags_in;
    logic       f;
    logic       b;
    logic       power;
    logic [1:0] lamps;

    assign has      = i_word.intent_mask;
    assign mem      = (i_word.memory_lamps == 2'b00) ? LAMP_BOTH : i_word.memory_lamps;
    assign sel      = has[INT_FRONT] | has[INT_BACK];
    assign flags_in = has[INT_POWER] | sel;
    assign f = has[INT_FRONT] ? i_word.want_front
                              : (i_word.base_power & i_word.base_lamps[0]);
    assign b = has[INT_BACK] ? i_word.want_back
                             : (i_word.base_power & i_word.base_lamps[1]);

    always_comb begin
        power = i_word.base_power;
        lamps = i_word.base_lamps;
        if (has[INT_POWER] && !i_word.want_power) begin
            power = 1'b0;
            lamps = mem;
        end else if (sel && (f || b)) begin
            power = 1'b1;
            lamps = (f ? LAMP_FRONT : 2'b00) | (b ? LAMP_BACK : 2'b00);
        end else if (!sel && i_word.base_power) begin
            power = i_word.base_power;
        end else if (has[INT_POWER]) begin
            power = 1'b1;
            lamps = mem;
        end else if (sel) begin
            power = 1'b0;
            lamps = mem;
        end
    end

    always_comb begin
        o_res                     = '0;
        o_res.power               = power;
        o_res.lamps               = lamps;
        o_res.changed[CHG_POWER]  = flags_in;
        o_res.changed[CHG_BRIGHT] = has[INT_LEVEL];
        o_res.changed[CHG_TEMP]   = has[INT_MIREDS];
        o_res.fire                = has[INT_AUTO] & power & ~flags_in;
    end

endmodule

`default_nettype wire

@@ rtl/core/lir_bright.sv @@
// Level to raw brightness mapping through the linear or square curve table.
`timescale 1ns / 1ps
`default_nettype none

module lir_bright
    import lir_pkg::*;
(
    input  var logic       i_curve_mode,
    input  var logic       i_use_level,
    input  var logic [7:0] i_level,
    input  var logic [7:0] i_base_bright,
    output var logic [7:0] o_bright
);

    logic [7:0] x;
    logic [7:0] v;

    always_comb begin
        if (i_level == 8'd0) begin
            x = 8'd0;
        end else if (i_level > LEVEL_MAX) begin
            x = LEVEL_MAX - 8'd1;
        end else begin
            x = i_level - 8'd1;
        end
    end

    assign v        = (i_curve_mode == CURVE_SQUARE) ? SQ_TAB[x] : LIN_TAB[x];
    assign o_bright = i_use_level ? (8'(BRIGHT_MIN) + v) : i_base_bright;

endmodule

`default_nettype wire

@@ rtl/core/lir_temp.sv @@
// Mireds clamp and mapping to a temperature step of 0 to 100.
`timescale 1ns / 1ps
`default_nettype none

module lir_temp
    import lir_pkg::*;
(
    input  var logic        i_use_mireds,
    input  var logic [15:0] i_mireds,
    input  var logic [7:0]  i_base_temp,
    output var logic [7:0]  o_temp
);

    logic [15:0] diff;
    logic [7:0]  d;

    assign diff = i_mireds - MIRED_COLD;

    always_comb begin
        if (i_mireds < MIRED_COLD) begin
            d = 8'd0;
        end else if (i_mireds > MIRED_WARM) begin
            d = DIFF_MAX;
        end else begin
            d = diff[7:0];
        end
    end

    assign o_temp = i_use_mireds ? TEMP_TAB[d] : i_base_temp;

endmodule

`default_nettype wire

@@ rtl/core/lir_checker.sv @@
// Port-level checker for the lamp intent resolver and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lir_checker
    import lir_pkg::*;
(
    input var logic      i_clk,
    input var logic      i_rst_n,
    input var logic      i_cfg_we,
    input var logic      i_cfg_wdata,
    input var logic      i_valid,
    input var logic      o_stall,
    input var t_in_word  i_word,
    input var logic      o_valid,
    input var logic      i_stall,
    input var t_out_word o_word
);

    // A word held by a stall stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("output word changed while stalled");

    // The output register is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // An accepted word with an empty output stage shows up once it has passed both registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> ##1 o_valid)
        else $error("accepted word did not reach the output");

    // Auto mode only starts with power on and no power or lamp intent.
    a_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.fire_auto |->
            o_word.target_power && !o_word.changed_fields[CHG_POWER])
        else $error("auto trigger without its conditions");

    // A mapped brightness and temperature stay within their ranges.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (!o_word.changed_fields[CHG_BRIGHT] ||
                (o_word.target_bright >= 8'd76 && o_word.target_bright <= 8'd254)) &&
            (!o_word.changed_fields[CHG_TEMP] || o_word.target_temp <= 8'd100))
        else $error("mapped value out of range");

endmodule

bind lamp_intent_resolver_core lir_checker u_lir_checker (.*);

`default_nettype wire
